// File: rtl/core/dcdc_pkg.sv
// Package for the DC-DC duty controller: types, constants and command structs.
// Used by the controller, the datapath and the top level.
package dcdc_pkg;

	localparam int unsigned VW = 20;
	localparam int unsigned DW = 17;
	localparam int unsigned IW = 48;
	localparam int unsigned QW = 37;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_EN = 2'd1;
	localparam logic [1:0] KIND_DIS = 2'd2;
	localparam logic [1:0] KIND_RSVD = 2'd3;

	localparam logic [2:0] REG_SETPOINT = 3'd0;
	localparam logic [2:0] REG_STEP = 3'd1;
	localparam logic [2:0] REG_KP = 3'd2;
	localparam logic [2:0] REG_KI = 3'd3;
	localparam logic [2:0] REG_FF = 3'd4;
	localparam logic [2:0] REG_DMIN = 3'd5;
	localparam logic [2:0] REG_DMAX = 3'd6;
	localparam logic [2:0] REG_DRMAX = 3'd7;

	localparam logic signed [IW-1:0] PI_LIM = 48'sd164920033280;
	localparam logic [16:0] VIN_MIN_MV = 17'd1000;
	localparam logic [5:0] DIV_STEPS = 6'd37;

	typedef struct packed {
		logic load;
		logic ramp;
		logic mul;
		logic div_start;
		logic div_step;
		logic integ;
		logic pi;
		logic finish;
		logic enable;
		logic disable_clr;
		logic idle_tick;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic enabled;
	} dp_sts_t;

endpackage

// File: rtl/core/dcdc_ctrl.sv
// Sequencer for the DC-DC duty controller: steps each item through the datapath.
// Depends on dcdc_pkg.
module dcdc_ctrl import dcdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] in_kind,
	output logic in_ready,
	input logic out_free,
	output logic out_load,
	output dp_cmd_t cmd,
	input dp_sts_t sts
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_RAMP = 8'b00000010,
		S_MUL = 8'b00000100,
		S_DIVS = 8'b00001000,
		S_DIV = 8'b00010000,
		S_INT = 8'b00100000,
		S_PI = 8'b01000000,
		S_FIN = 8'b10000000
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE) && out_free;

	always_comb begin
		cmd = '0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && out_free) begin
					cmd.load = 1'b1;
					case (in_kind)
						KIND_EN: begin
							cmd.enable = 1'b1;
							out_load = 1'b1;
						end
						KIND_DIS: begin
							cmd.disable_clr = 1'b1;
							out_load = 1'b1;
						end
						KIND_TICK: begin
							if (!sts.enabled) begin
								cmd.idle_tick = 1'b1;
								out_load = 1'b1;
							end
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			S_RAMP: cmd.ramp = 1'b1;
			S_MUL: cmd.mul = 1'b1;
			S_DIVS: cmd.div_start = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_INT: cmd.integ = 1'b1;
			S_PI: cmd.pi = 1'b1;
			S_FIN: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && out_free && in_kind == KIND_TICK && sts.enabled)
						state_q <= S_RAMP;
				end
				S_RAMP: state_q <= S_MUL;
				S_MUL: state_q <= S_DIVS;
				S_DIVS: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) state_q <= S_INT;
				end
				S_INT: state_q <= S_PI;
				S_PI: state_q <= S_FIN;
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/dcdc_dp.sv
// Datapath for the DC-DC duty controller: ramp, feedforward divider, PI and clamps.
// Depends on dcdc_pkg; driven by dcdc_ctrl.
module dcdc_dp import dcdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	output dp_sts_t sts,
	input logic [16:0] vin,
	input logic [19:0] vbus,
	input logic [19:0] setpoint,
	input logic [15:0] step,
	input logic [23:0] kp,
	input logic [23:0] ki,
	input logic [16:0] ffg,
	input logic [16:0] dmin,
	input logic [16:0] dmax,
	input logic [16:0] drmax,
	output logic [16:0] duty,
	output logic enabled,
	output logic [19:0] ramp
);

	logic enabled_q;
	logic [19:0] ramp_q;
	logic signed [IW-1:0] integ_q;
	logic [16:0] duty_q;
	logic [16:0] vin_q;
	logic [19:0] vbus_q;
	logic signed [20:0] err_q;
	logic [QW-1:0] num_q;
	logic [QW-1:0] quo_q;
	logic [17:0] rem_q;
	logic [5:0] cnt_q;
	logic signed [IW-1:0] pterm_q;
	logic signed [IW-1:0] pi_q;

	logic [20:0] ramp_sum;
	logic [19:0] ramp_nxt;
	logic [18:0] rem_sh;
	logic [18:0] rem_sub;
	logic signed [IW:0] isum;
	logic signed [IW:0] psum;
	logic signed [IW:0] lim_e;
	logic signed [IW-1:0] iclamp;
	logic signed [IW-1:0] pclamp;
	logic [QW-1:0] ffc;
	logic [QW-1:0] ff_prod;
	logic signed [45:0] ki_prod;
	logic signed [45:0] kp_prod;
	logic signed [19:0] ff;
	logic signed [19:0] corr;
	logic signed [19:0] sum;
	logic [16:0] ceil;
	logic [15:0] step_e;
	logic signed [IW-1:0] pi_shift;

	assign step_e = (step == 16'd0) ? 16'd1 : step;
	assign ramp_sum = {1'b0, ramp_q} + {5'd0, step_e};
	always_comb begin
		if (ramp_q < setpoint)
			ramp_nxt = (ramp_sum > {1'b0, setpoint}) ? setpoint : ramp_sum[19:0];
		else
			ramp_nxt = setpoint;
	end

	assign ff_prod = ramp_q * ffg;
	assign ki_prod = $signed({1'b0, ki}) * err_q;
	assign kp_prod = $signed({1'b0, kp}) * err_q;

	assign rem_sh = {rem_q, num_q[QW-1]};
	assign rem_sub = rem_sh - {2'd0, vin_q};

	assign lim_e = {PI_LIM[IW-1], PI_LIM};
	assign isum = {pterm_q[IW-1], pterm_q} + {integ_q[IW-1], integ_q};
	assign iclamp = (isum < -lim_e) ? -PI_LIM :
		(isum > lim_e) ? PI_LIM : isum[IW-1:0];
	assign psum = {pterm_q[IW-1], pterm_q} + {integ_q[IW-1], integ_q};
	assign pclamp = (psum < -lim_e) ? -PI_LIM :
		(psum > lim_e) ? PI_LIM : psum[IW-1:0];

	always_comb begin
		if (vin_q < VIN_MIN_MV) begin
			ffc = {20'd0, dmin};
		end else if (quo_q < {20'd0, dmin}) begin
			ffc = {20'd0, dmin};
		end else if (quo_q > {20'd0, dmax}) begin
			ffc = {20'd0, dmax};
		end else begin
			ffc = quo_q;
		end
		ff = signed'({3'd0, ffc[16:0]});
		pi_shift = (pi_q + PI_LIM) >>> 24;
		corr = pi_shift[19:0] - 20'sd9830;
		sum = ff + corr;
		ceil = ((ramp_q < setpoint) && (dmax > drmax)) ? drmax : dmax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			ramp_q <= '0;
			integ_q <= '0;
			duty_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				vin_q <= vin;
				vbus_q <= vbus;
			end
			if (cmd.enable) enabled_q <= 1'b1;
			if (cmd.disable_clr) begin
				enabled_q <= 1'b0;
				ramp_q <= '0;
				integ_q <= '0;
				duty_q <= '0;
			end
			if (cmd.idle_tick) duty_q <= '0;
			if (cmd.ramp) ramp_q <= ramp_nxt;
			if (cmd.mul) begin
				num_q <= ff_prod;
				err_q <= $signed({1'b0, ramp_q}) - $signed({1'b0, vbus_q});
			end
			if (cmd.div_start) begin
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= DIV_STEPS;
				pterm_q <= IW'(ki_prod);
			end
			if (cmd.div_step && cnt_q != 6'd0) begin
				if (!rem_sub[18]) begin
					rem_q <= rem_sub[17:0];
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[17:0];
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
				num_q <= {num_q[QW-2:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
			end
			if (cmd.integ) begin
				integ_q <= iclamp;
				pterm_q <= IW'(kp_prod);
			end
			if (cmd.pi) pi_q <= pclamp;
			if (cmd.finish) begin
				if (sum < $signed({3'd0, dmin})) duty_q <= dmin;
				else if (sum > $signed({3'd0, ceil})) duty_q <= ceil;
				else duty_q <= sum[16:0];
			end
		end
	end

	assign sts.div_done = (cnt_q == 6'd1) || (cmd.div_step && cnt_q == 6'd0);
	assign sts.enabled = enabled_q;
	assign duty = duty_q;
	assign enabled = enabled_q;
	assign ramp = ramp_q;

endmodule

// File: rtl/core/dcdc_duty_pi_softstart.sv
// Top level of the DC-DC duty controller: stream ports, register file, output register.
// Depends on dcdc_pkg, dcdc_ctrl and dcdc_dp.
//
// A tick goes through the ramp, the multiply and the divider start, restoring division
// for the feedforward quotient, then the integrator, the PI sum and the final clamp; the
// out_load_d_q register then loads the output register. Enable, disable, unused kinds and
// ticks while disabled are handled on acceptance and reach the output register the same
// way. One item is worked on at a time and the next is accepted only after the result
// has been taken.
module dcdc_duty_pi_softstart import dcdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [39:0] s_tdata, // vin_mv[16:0], vbus_mv[36:17], zero fill
	input logic [1:0] s_tuser, // kind
	output logic m_tvalid,
	input logic m_tready,
	output logic [39:0] m_tdata, // duty[16:0], ramp_ref_mv[36:17], zero fill
	output logic [1:0] m_tuser, // pwm_on[0], soft_starting[1]
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data
);

	logic [19:0] setpoint_q;
	logic [15:0] step_q;
	logic [23:0] kp_q, ki_q;
	logic [16:0] ffg_q, dmin_q, dmax_q, drmax_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic out_load, out_free, out_load_d_q;
	logic [16:0] duty;
	logic en;
	logic [19:0] ramp;
	logic m_valid_q;
	logic [39:0] m_data_q;
	logic [1:0] m_user_q;
	logic pending_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= 20'd400000;
			step_q <= 16'd1;
			kp_q <= 24'd879609;
			ki_q <= 24'd659;
			ffg_q <= 17'd16384;
			dmin_q <= 17'd0;
			dmax_q <= 17'd62259;
			drmax_q <= 17'd32768;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SETPOINT: setpoint_q <= cfg_data[19:0];
				REG_STEP: step_q <= cfg_data[15:0];
				REG_KP: kp_q <= cfg_data;
				REG_KI: ki_q <= cfg_data;
				REG_FF: ffg_q <= cfg_data[16:0];
				REG_DMIN: dmin_q <= cfg_data[16:0];
				REG_DMAX: dmax_q <= cfg_data[16:0];
				REG_DRMAX: drmax_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign out_free = !m_valid_q && !pending_q;

	dcdc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_kind(s_tuser), .in_ready(s_tready),
		.out_free(out_free), .out_load(out_load), .cmd(cmd), .sts(sts)
	);

	dcdc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.vin(s_tdata[16:0]), .vbus(s_tdata[36:17]),
		.setpoint(setpoint_q), .step(step_q), .kp(kp_q), .ki(ki_q), .ffg(ffg_q),
		.dmin(dmin_q), .dmax(dmax_q), .drmax(drmax_q),
		.duty(duty), .enabled(en), .ramp(ramp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			pending_q <= 1'b0;
			out_load_d_q <= 1'b0;
		end else begin
			out_load_d_q <= out_load || cmd.finish;
			pending_q <= (s_tvalid && s_tready) ? 1'b1 : (out_load_d_q ? 1'b0 : pending_q);
			if (out_load_d_q) begin
				m_valid_q <= 1'b1;
				m_data_q <= {3'd0, ramp, duty};
				m_user_q <= {en && (ramp < setpoint_q), en};
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;

endmodule

// File: dv/dcdc_duty_pi_softstart_tb.sv
// Testbench for the DC-DC duty controller with PI loop and soft-start ramp.
// Drives ticks and enable/disable items, predicts each result in a local model.
// Depends on dcdc_pkg and the dcdc_duty_pi_softstart RTL.
`timescale 1ns / 100ps

module dcdc_duty_pi_softstart_tb import dcdc_pkg::*;;

	typedef struct packed {
		logic [1:0] kind;
		logic [16:0] vin;
		logic [19:0] vbus;
	} ctl_item_t;

	typedef struct packed {
		logic [16:0] duty;
		logic pwm_on;
		logic soft_st;
		logic [19:0] ramp;
	} duty_res_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [39:0] s_tdata, m_tdata;
	logic [1:0] s_tuser, m_tuser;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_taken;

	ctl_item_t pending_items[$];
	duty_res_t expected_duty[$];
	int errors = 0;
	int send_idle_pct = 9;
	int recv_idle_pct = 59;

	logic [19:0] m_setpoint;
	logic [15:0] m_step;
	logic [23:0] m_kp, m_ki;
	logic [16:0] m_ff, m_dmin, m_dmax, m_drmax;
	logic m_en;
	logic [19:0] m_ramp;
	longint m_integ;
	logic [16:0] m_duty;

	localparam longint LIM = 64'd164920033280;

	dcdc_duty_pi_softstart i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp64(longint x, longint lo, longint hi);
		if (x < lo) return lo;
		if (x > hi) return hi;
		return x;
	endfunction

	function automatic duty_res_t predict_duty(ctl_item_t it);
		duty_res_t r;
		longint stp, dmax, ff, err, pi40, corr;
		stp = (m_step == 0) ? 1 : longint'(m_step);
		if (it.kind == KIND_TICK) begin
			if (!m_en) begin
				m_duty = 0;
			end else begin
				if (m_ramp < m_setpoint) begin
					if (longint'(m_ramp) + stp > m_setpoint) m_ramp = m_setpoint;
					else m_ramp = m_ramp + 20'(stp);
				end else begin
					m_ramp = m_setpoint;
				end
				dmax = longint'(m_dmax);
				if (m_ramp < m_setpoint && m_dmax > m_drmax) dmax = longint'(m_drmax);
				if (it.vin < VIN_MIN_MV) begin
					ff = longint'(m_dmin);
				end else begin
					ff = (longint'(m_ramp) * longint'(m_ff)) / longint'(it.vin);
					ff = clamp64(ff, m_dmin, m_dmax);
				end
				err = longint'(m_ramp) - longint'(it.vbus);
				m_integ = clamp64(m_integ + longint'(m_ki) * err, -LIM, LIM);
				pi40 = clamp64(longint'(m_kp) * err + m_integ, -LIM, LIM);
				corr = ((pi40 + LIM) >>> 24) - 9830;
				m_duty = 17'(clamp64(ff + corr, m_dmin, dmax));
			end
		end else if (it.kind == KIND_EN) begin
			m_en = 1;
		end else if (it.kind == KIND_DIS) begin
			m_en = 0;
			m_ramp = 0;
			m_integ = 0;
			m_duty = 0;
		end
		r.duty = m_duty;
		r.pwm_on = m_en;
		r.soft_st = m_en && (m_ramp < m_setpoint);
		r.ramp = m_ramp;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_taken <= 0;
		else in_taken <= s_tvalid && s_tready;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || in_taken) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				ctl_item_t it;
				it = pending_items.pop_front();
				expected_duty.push_back(predict_duty(it));
				s_tvalid <= 1;
				s_tuser <= it.kind;
				s_tdata <= {3'b0, it.vbus, it.vin};
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 0;
		else m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			duty_res_t exp_r;
			if (expected_duty.size() == 0) begin
				$display("%0t: result with none expected: %h", $time, m_tdata);
				errors++;
			end else begin
				exp_r = expected_duty.pop_front();
				if (m_tdata[16:0] !== exp_r.duty || m_tuser[0] !== exp_r.pwm_on ||
						m_tuser[1] !== exp_r.soft_st || m_tdata[36:17] !== exp_r.ramp ||
						m_tdata[39:37] !== 3'b0) begin
					$display("%0t: expected duty %0d on %b soft %b ramp %0d, got %0d %b %b %0d",
						$time, exp_r.duty, exp_r.pwm_on, exp_r.soft_st, exp_r.ramp,
						m_tdata[16:0], m_tuser[0], m_tuser[1], m_tdata[36:17]);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SETPOINT: m_setpoint = val[19:0];
			REG_STEP: m_step = val[15:0];
			REG_KP: m_kp = val;
			REG_KI: m_ki = val;
			REG_FF: m_ff = val[16:0];
			REG_DMIN: m_dmin = val[16:0];
			REG_DMAX: m_dmax = val[16:0];
			REG_DRMAX: m_drmax = val[16:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain_results();
		while (pending_items.size() > 0 || expected_duty.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic add_item(logic [1:0] k, logic [16:0] vin, logic [19:0] vbus);
		ctl_item_t it;
		it.kind = k;
		it.vin = vin;
		it.vbus = vbus;
		pending_items.push_back(it);
	endtask

	function automatic logic [19:0] m_ramp_guess();
		return (m_setpoint > 20'd2000) ? m_setpoint : 20'd2000;
	endfunction

	task automatic add_random(int n);
		logic [1:0] k;
		logic [16:0] vin;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(99) < 90) ? KIND_TICK : 2'($urandom_range(3));
			case ($urandom_range(3))
				0: vin = 17'($urandom_range(1100));
				1: vin = 17'($urandom);
				default: vin = 17'($urandom_range(60000, 1000));
			endcase
			if ($urandom_range(3) == 0)
				add_item(k, vin, 20'($urandom));
			else
				add_item(k, vin, 20'(longint'(m_ramp_guess()) + $urandom_range(4000) - 2000));
		end
	endtask

	task automatic random_config(bit extreme);
		write_reg(REG_SETPOINT, extreme ? 24'hFFFFF : 24'($urandom_range(60000, 500)));
		write_reg(REG_STEP, extreme ? 24'hFFFF : 24'($urandom_range(2000)));
		write_reg(REG_KP, extreme ? 24'hFFFFFF : 24'($urandom_range(2000000)));
		write_reg(REG_KI, extreme ? 24'($urandom) : 24'($urandom_range(5000)));
		write_reg(REG_FF, extreme ? 24'd65536 : 24'($urandom_range(65536)));
		write_reg(REG_DMIN, extreme ? 24'd65536 : 24'($urandom_range(3000)));
		write_reg(REG_DMAX, extreme ? 24'd0 : 24'($urandom_range(65536, 30000)));
		write_reg(REG_DRMAX, 24'($urandom_range(65536)));
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		m_setpoint = 400000; m_step = 1; m_kp = 879609; m_ki = 659;
		m_ff = 16384; m_dmin = 0; m_dmax = 62259; m_drmax = 32768;
		m_en = 0; m_ramp = 0; m_integ = 0; m_duty = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (3) @(posedge clk);

		// Tick while disabled, unused kind, enable, low and extreme inputs, then disable and a tick.
		add_item(KIND_TICK, 17'd48000, 20'd0);
		add_item(KIND_RSVD, 17'h1FFFF, 20'hFFFFF);
		add_item(KIND_EN, 17'd0, 20'd0);
		add_item(KIND_TICK, 17'd999, 20'd0);
		add_item(KIND_TICK, 17'd1000, 20'hFFFFF);
		add_item(KIND_TICK, 17'h1FFFF, 20'd5);
		add_item(KIND_RSVD, 17'd0, 20'd0);
		add_item(KIND_DIS, 17'd0, 20'd0);
		add_item(KIND_TICK, 17'd48000, 20'd0);
		drain_results();

		write_reg(REG_SETPOINT, 24'd3000);
		write_reg(REG_STEP, 24'd0);
		write_reg(REG_DMIN, 24'd40000);
		write_reg(REG_DMAX, 24'd20000);
		add_item(KIND_EN, 17'd0, 20'd0);
		repeat (4) add_item(KIND_TICK, 17'd12000, 20'd0);
		drain_results();
		// Setpoint below the ramp, with an extreme step; the ramp is set to the setpoint at once.
		write_reg(REG_SETPOINT, 24'd1);
		write_reg(REG_STEP, 24'hFFFF);
		write_reg(REG_DMIN, 24'd0);
		write_reg(REG_DMAX, 24'd65536);
		add_item(KIND_TICK, 17'd1000, 20'hFFFFF);
		add_item(KIND_TICK, 17'd1000, 20'd0);
		drain_results();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin send_idle_pct = 59; recv_idle_pct = 9; end
			if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
			random_config(ph == 1);
			add_item(KIND_EN, 17'd0, 20'd0);
			add_random(320);
			drain_results();
		end

		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/dcdc_pkg.sv
rtl/core/dcdc_ctrl.sv
rtl/core/dcdc_dp.sv
rtl/core/dcdc_duty_pi_softstart.sv
dv/dcdc_duty_pi_softstart_tb.sv
